// ===== rtl/core/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and codes for the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

  // command opcodes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SIZE       = 3'd4;
  localparam logic [2:0] OP_EMPTY      = 3'd5;
  localparam logic [2:0] OP_FRONT      = 3'd6;
  localparam logic [2:0] OP_BACK       = 3'd7;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int OUT_WIDTH = 32;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } result_t;

  // registered response control from the pointer unit
  typedef struct packed {
    logic                 valid;
    logic                 from_mem;
    logic [1:0]           status;
    logic [OUT_WIDTH-1:0] imm;
  } rsp_ctl_t;

endpackage

// ===== rtl/core/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// word store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// command decode, head and count registers, store access and response control
// ----------------------------------------------------------------------------
module dq_ctrl #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  dq_pkg::cmd_t          cmd,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output logic [DATA_WIDTH-1:0] wdata,
  output logic                  re,
  output logic [AW-1:0]         raddr,
  output dq_pkg::rsp_ctl_t      rsp
);
  import dq_pkg::*;

  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  rsp_ctl_t      rsp_next;

  logic          full, empty;
  logic [AW-1:0] head_inc, head_dec, tail_idx, back_idx;
  logic [SW-1:0] sum_tail, sum_back;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);

  assign head_inc = (head == LAST_IDX) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? LAST_IDX : head - AW'(1);

  // ring wrap by one compare and subtract
  always_comb begin
    sum_tail = SW'(head) + SW'(count);
    sum_back = SW'(head) + SW'(count) - SW'(1);
    if (sum_tail >= DEPTH_S) begin
      sum_tail = sum_tail - DEPTH_S;
    end
    if (sum_back >= DEPTH_S) begin
      sum_back = sum_back - DEPTH_S;
    end
    tail_idx = sum_tail[AW-1:0];
    back_idx = sum_back[AW-1:0];
  end

  always_comb begin
    head_next         = head;
    count_next        = count;
    we                = 1'b0;
    waddr             = tail_idx;
    wdata             = DATA_WIDTH'(cmd.push_value);
    re                = 1'b0;
    raddr             = head;
    rsp_next.valid    = 1'b0;
    rsp_next.from_mem = 1'b0;
    rsp_next.status   = ST_OK;
    rsp_next.imm      = '0;
    if (accept) begin
      case (cmd.opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            rsp_next.valid  = 1'b1;
            rsp_next.status = ST_FULL;
          end else begin
            we         = 1'b1;
            count_next = count + CW'(1);
            if (cmd.opcode == OP_PUSH_FRONT) begin
              head_next = head_dec;
              waddr     = head_dec;
            end
          end
        end
        OP_SIZE: begin
          rsp_next.valid = 1'b1;
          rsp_next.imm   = OUT_WIDTH'(count);
        end
        OP_EMPTY: begin
          rsp_next.valid = 1'b1;
          rsp_next.imm   = OUT_WIDTH'(empty);
        end
        default: begin
          // pops and peeks
          rsp_next.valid = 1'b1;
          if (empty) begin
            rsp_next.status = ST_EMPTY;
            rsp_next.imm    = '1;
          end else begin
            re                = 1'b1;
            rsp_next.from_mem = 1'b1;
            if (cmd.opcode == OP_POP_BACK || cmd.opcode == OP_BACK) begin
              raddr = back_idx;
            end
            if (cmd.opcode == OP_POP_FRONT) begin
              head_next  = head_inc;
              count_next = count - CW'(1);
            end else if (cmd.opcode == OP_POP_BACK) begin
              count_next = count - CW'(1);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      rsp.valid <= rsp_next.valid;
    end
    rsp.from_mem <= rsp_next.from_mem;
    rsp.status   <= rsp_next.status;
    rsp.imm      <= rsp_next.imm;
  end

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// double-ended queue of words in a ring store, driven by one command a transfer
// ----------------------------------------------------------------------------
//
// channel   direction  qualifier              payload
// command   in         start && !busy         cmd    (opcode, push_value)
// result    out        result_valid (1 cycle) result (result_value, status)
//
// one command per cycle unless busy; a command giving a result shows it on the
// cycle after its transfer, read data straight off the store's output register
// busy is high during reset and in the cycle after it; no clearing pass
// head and count update at the command transfer, so the next command sees them
// the result strobe lasts one cycle and cannot be held off by the receiver
//
module double_ended_queue #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dq_pkg::cmd_t     cmd,
  output logic             result_valid,
  output dq_pkg::result_t  result
);
  import dq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  accept;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  rsp_ctl_t              rsp;
  logic [63:0]           rdata_wide;

  // command transfer
  assign accept = start && !busy;

  // hold off commands for the cycle that follows reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // pointer unit: decodes the command and issues at most one store access
  dq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr  (raddr),
    .rsp    (rsp)
  );

  // word store
  dq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sign extend the stored word to 64 bits; the result takes its low OUT_WIDTH bits
  assign rdata_wide = 64'(signed'(rdata));

  assign result_valid        = rsp.valid;
  assign result.status       = rsp.status;
  assign result.result_value = rsp.from_mem ? rdata_wide[OUT_WIDTH-1:0] : rsp.imm;

`ifndef ASSERT_OFF
  // every result follows a command transfer in the previous cycle
  a_result_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept))
    else $error("result without a preceding command transfer");

  // a dropped push reports a zero value
  a_full_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_FULL) |-> (result.result_value == 0))
    else $error("full status with nonzero value");

  // an empty pop or peek reports minus one
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_EMPTY) |-> (result.result_value == -1))
    else $error("empty status without minus one");

  // a successful push produces no result
  a_push_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.opcode == OP_PUSH_FRONT || cmd.opcode == OP_PUSH_BACK) && we)
      |=> !result_valid)
    else $error("result after a successful push");
`endif

endmodule
